>>> rtl/core/terminal_escape_filter_line_buffer_defines.svh
// Assertion macros for the terminal escape filter line buffer.
// Used by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef TERMINAL_ESCAPE_FILTER_LINE_BUFFER_DEFINES_SVH
`define TERMINAL_ESCAPE_FILTER_LINE_BUFFER_DEFINES_SVH

`ifndef SYNTH

// Condition holds at every clock edge out of reset.
`define TEFL_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TEFL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TEFL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TEFL_ASSERT(label, cond, msg)
`define TEFL_ASSERT_IMP(label, ante, cons, msg)
`define TEFL_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/core/tefl_pkg.sv
// Shared types, field widths and codes for the terminal escape filter line buffer.
// No dependencies; every RTL module refers to it by scoped names.
package tefl_pkg;

  // Default geometry
  localparam int DEF_SCREEN_LINES = 64;
  localparam int DEF_SCREEN_COLS  = 32;
  localparam int DEF_RAW_DEPTH    = 1024;

  // Port field widths
  localparam int CMD_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int LINE_IDX_W = 6;
  localparam int COL_W      = 5;
  localparam int RAW_IDX_W  = 10;
  localparam int LINE_CNT_W = 7;
  localparam int CUR_COL_W  = 6;
  localparam int RAW_CNT_W  = 11;
  localparam int TOTAL_W    = 32;
  localparam int PSTATE_W   = 3;
  localparam int CELL_W     = 7;
  localparam int OP_W       = 3;

  localparam int TAB_STOP = 8;

  // Commands
  localparam logic [CMD_W-1:0] CMD_FEED_RX     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FEED_ECHO   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_SCREEN = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ_RAW    = 2'd3;

  // Parser states
  localparam logic [PSTATE_W-1:0] PS_NORMAL  = 3'd0;
  localparam logic [PSTATE_W-1:0] PS_ESC     = 3'd1;
  localparam logic [PSTATE_W-1:0] PS_CSI     = 3'd2;
  localparam logic [PSTATE_W-1:0] PS_OSC     = 3'd3;
  localparam logic [PSTATE_W-1:0] PS_OSC_ESC = 3'd4;
  localparam logic [PSTATE_W-1:0] PS_SWALLOW = 3'd5;

  // Byte values
  localparam logic [BYTE_W-1:0] CH_BEL      = 8'h07;
  localparam logic [BYTE_W-1:0] CH_BS       = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_HASH     = 8'h23;
  localparam logic [BYTE_W-1:0] CH_LPAREN   = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN   = 8'h29;
  localparam logic [BYTE_W-1:0] CH_FINAL_LO = 8'h40;
  localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_BSLASH   = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_RBRACKET = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_TILDE    = 8'h7E;

  // Operations handed from the front to the back
  localparam logic [OP_W-1:0] OP_NOP       = 3'd0;
  localparam logic [OP_W-1:0] OP_PRINT     = 3'd1;
  localparam logic [OP_W-1:0] OP_LF        = 3'd2;
  localparam logic [OP_W-1:0] OP_CR        = 3'd3;
  localparam logic [OP_W-1:0] OP_BS        = 3'd4;
  localparam logic [OP_W-1:0] OP_TAB       = 3'd5;
  localparam logic [OP_W-1:0] OP_RD_SCREEN = 3'd6;
  localparam logic [OP_W-1:0] OP_RD_RAW    = 3'd7;

  // Decoupling queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic                  raw_feed;
    logic [BYTE_W-1:0]     data_byte;
    logic [LINE_IDX_W-1:0] line_index;
    logic [COL_W-1:0]      column;
    logic [RAW_IDX_W-1:0]  raw_index;
    logic [PSTATE_W-1:0]   pstate;
  } entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0]     read_data;
    logic [LINE_CNT_W-1:0] line_count;
    logic [CUR_COL_W-1:0]  cursor_column;
    logic [RAW_CNT_W-1:0]  raw_level;
    logic [TOTAL_W-1:0]    total_received;
    logic [PSTATE_W-1:0]   parser_state;
  } result_t;

endpackage

>>> rtl/core/tefl_front.sv
// Front end: accepts input words, runs the escape parser and classifies each word
// into a back-end operation. Depends on tefl_pkg.
module tefl_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic [tefl_pkg::CMD_W-1:0]      in_command,
  input  logic [tefl_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic [tefl_pkg::LINE_IDX_W-1:0] in_line_index,
  input  logic [tefl_pkg::COL_W-1:0]      in_column,
  input  logic [tefl_pkg::RAW_IDX_W-1:0]  in_raw_index,
  input  logic                            q_full,
  output logic                            q_push,
  output tefl_pkg::entry_t                q_entry
);

  logic [tefl_pkg::PSTATE_W-1:0] esc_state_r;
  logic [tefl_pkg::PSTATE_W-1:0] esc_state_nxt;
  logic [tefl_pkg::OP_W-1:0]     op;

  always_comb begin
    esc_state_nxt = esc_state_r;
    op            = tefl_pkg::OP_NOP;
    case (in_command)
      tefl_pkg::CMD_FEED_RX, tefl_pkg::CMD_FEED_ECHO: begin
        case (esc_state_r)
          tefl_pkg::PS_NORMAL: begin
            if (in_data_byte == tefl_pkg::CH_ESC) begin
              esc_state_nxt = tefl_pkg::PS_ESC;
            end else if (in_data_byte >= tefl_pkg::CH_SPACE &&
                         in_data_byte <= tefl_pkg::CH_TILDE) begin
              op = tefl_pkg::OP_PRINT;
            end else begin
              case (in_data_byte)
                tefl_pkg::CH_LF:  op = tefl_pkg::OP_LF;
                tefl_pkg::CH_CR:  op = tefl_pkg::OP_CR;
                tefl_pkg::CH_BS:  op = tefl_pkg::OP_BS;
                tefl_pkg::CH_TAB: op = tefl_pkg::OP_TAB;
                default:          op = tefl_pkg::OP_NOP;
              endcase
            end
          end
          tefl_pkg::PS_ESC: begin
            if (in_data_byte == tefl_pkg::CH_LBRACKET) begin
              esc_state_nxt = tefl_pkg::PS_CSI;
            end else if (in_data_byte == tefl_pkg::CH_RBRACKET) begin
              esc_state_nxt = tefl_pkg::PS_OSC;
            end else if (in_data_byte == tefl_pkg::CH_LPAREN ||
                         in_data_byte == tefl_pkg::CH_RPAREN ||
                         in_data_byte == tefl_pkg::CH_HASH) begin
              esc_state_nxt = tefl_pkg::PS_SWALLOW;
            end else begin
              esc_state_nxt = tefl_pkg::PS_NORMAL;
            end
          end
          tefl_pkg::PS_CSI: begin
            if (in_data_byte >= tefl_pkg::CH_FINAL_LO &&
                in_data_byte <= tefl_pkg::CH_TILDE) begin
              esc_state_nxt = tefl_pkg::PS_NORMAL;
            end
          end
          tefl_pkg::PS_OSC: begin
            if (in_data_byte == tefl_pkg::CH_BEL) begin
              esc_state_nxt = tefl_pkg::PS_NORMAL;
            end else if (in_data_byte == tefl_pkg::CH_ESC) begin
              esc_state_nxt = tefl_pkg::PS_OSC_ESC;
            end
          end
          tefl_pkg::PS_OSC_ESC: begin
            esc_state_nxt = (in_data_byte == tefl_pkg::CH_BSLASH) ?
                            tefl_pkg::PS_NORMAL : tefl_pkg::PS_OSC;
          end
          default: begin
            // swallow one byte after ESC ( ) #
            esc_state_nxt = tefl_pkg::PS_NORMAL;
          end
        endcase
      end
      tefl_pkg::CMD_READ_SCREEN: op = tefl_pkg::OP_RD_SCREEN;
      default:                   op = tefl_pkg::OP_RD_RAW;
    endcase
  end

  assign q_push = in_push && !q_full;

  always_comb begin
    q_entry.op         = op;
    q_entry.raw_feed   = (in_command == tefl_pkg::CMD_FEED_RX);
    q_entry.data_byte  = in_data_byte;
    q_entry.line_index = in_line_index;
    q_entry.column     = in_column;
    q_entry.raw_index  = in_raw_index;
    q_entry.pstate     = esc_state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_state_r <= tefl_pkg::PS_NORMAL;
    end else if (q_push) begin
      esc_state_r <= esc_state_nxt;
    end
  end

endmodule

>>> rtl/core/tefl_queue.sv
// Short queue of classified operations between the front and back ends.
// Depends on tefl_pkg for the entry type and depth.
module tefl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tefl_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output tefl_pkg::entry_t pop_entry,
  output logic             empty
);

  tefl_pkg::entry_t                mem_r [tefl_pkg::QUEUE_DEPTH];
  logic [tefl_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [tefl_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [tefl_pkg::QCNT_W-1:0]     count_r;
  logic                            do_push;
  logic                            do_pop;

  assign full      = (count_r == tefl_pkg::QCNT_W'(tefl_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == tefl_pkg::QPTR_W'(tefl_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == tefl_pkg::QPTR_W'(tefl_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/tefl_back.sv
// Back end: executes screen, raw-log and read operations against the line ring,
// the per-line fill marks and the raw ring, and holds the result word.
// Depends on tefl_pkg and the assertion macro header.
`include "terminal_escape_filter_line_buffer_defines.svh"

module tefl_back #(
  parameter int SCREEN_LINES = tefl_pkg::DEF_SCREEN_LINES,
  parameter int SCREEN_COLS  = tefl_pkg::DEF_SCREEN_COLS,
  parameter int RAW_DEPTH    = tefl_pkg::DEF_RAW_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  tefl_pkg::entry_t  q_entry,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_valid,
  output tefl_pkg::result_t out_result
);

  localparam int LW      = $clog2(SCREEN_LINES);
  localparam int UW      = $clog2(SCREEN_LINES + 1);
  localparam int CW      = $clog2(SCREEN_COLS);
  localparam int CCW     = $clog2(SCREEN_COLS + 1);
  localparam int DW      = (RAW_DEPTH > 1) ? $clog2(RAW_DEPTH) : 1;
  localparam int FW      = $clog2(RAW_DEPTH + 1);
  localparam int LCMP_W  = (UW > tefl_pkg::LINE_IDX_W) ? UW : tefl_pkg::LINE_IDX_W;
  localparam int CCMP_W  = (CCW > tefl_pkg::COL_W) ? CCW : tefl_pkg::COL_W;
  localparam int RCMP_W  = (FW > tefl_pkg::RAW_IDX_W) ? FW : tefl_pkg::RAW_IDX_W;
  localparam int CELL_AW = LW + CW;
  localparam int CELL_DEPTH = SCREEN_LINES << CW;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // Storage
  logic [tefl_pkg::CELL_W-1:0] cell_mem [0:CELL_DEPTH-1];
  logic [CCW-1:0]              hw_mem   [0:SCREEN_LINES-1];
  logic [tefl_pkg::BYTE_W-1:0] raw_mem  [0:RAW_DEPTH-1];
  logic [tefl_pkg::CELL_W-1:0] cell_rd_r;
  logic [CCW-1:0]              hw_rd_r;
  logic [tefl_pkg::BYTE_W-1:0] raw_rd_r;

  // Control and state registers
  logic [1:0]                  state_r, state_nxt;
  tefl_pkg::entry_t            cur_r, cur_nxt;
  logic [LW-1:0]               newest_r, newest_nxt;
  logic [UW-1:0]               used_r, used_nxt;
  logic [CCW-1:0]              cursor_r, cursor_nxt;
  logic [CCW-1:0]              hw_r, hw_nxt;
  logic                        tab_first_r, tab_first_nxt;
  logic                        rd_ok_r, rd_ok_nxt;
  logic                        rd_newest_r, rd_newest_nxt;
  logic [DW-1:0]               wp_r, wp_nxt;
  logic [FW-1:0]               fill_r, fill_nxt;
  logic [tefl_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic                        out_valid_r, out_valid_nxt;
  tefl_pkg::result_t           result_r, result_nxt;

  // Memory ports
  logic                        cell_we, cell_re;
  logic [LW-1:0]               cell_wrow;
  logic [CW-1:0]               cell_wcol;
  logic [CELL_AW-1:0]          cell_waddr, cell_raddr;
  logic [tefl_pkg::CELL_W-1:0] cell_wdata;
  logic                        hw_we, hw_re;
  logic                        raw_we, raw_re;
  logic [DW-1:0]               raw_raddr;

  // Helpers
  logic [LW-1:0]               newest_inc;
  logic [UW-1:0]               used_inc;
  logic [CCW-1:0]              cursor_inc;
  logic [CCW-1:0]              hw_grow;
  logic                        line_ok, col_ok, raw_ok;
  logic [UW-1:0]               row_dist;
  logic [LW:0]                 row_sum;
  logic [LW-1:0]               row_sel;
  logic [FW-1:0]               raw_dist;
  logic [DW:0]                 raw_sum;
  logic [CCW-1:0]              hw_sel;
  logic [tefl_pkg::BYTE_W-1:0] rd_val;
  logic                        out_take;
  logic                        tab_more;

  assign out_take   = out_pop && out_valid_r;
  assign newest_inc = (newest_r == LW'(SCREEN_LINES - 1)) ? '0 : newest_r + 1'b1;
  assign used_inc   = (used_r < UW'(SCREEN_LINES)) ? used_r + 1'b1 : used_r;
  assign cursor_inc = cursor_r + 1'b1;
  assign hw_grow    = (cursor_inc > hw_r) ? cursor_inc : hw_r;
  assign tab_more   = (cursor_r < CCW'(SCREEN_COLS)) &&
                      (tab_first_r || ((cursor_r & CCW'(tefl_pkg::TAB_STOP - 1)) != '0));

  // Oldest-relative line to ring row: newest minus distance, wrapped
  assign line_ok  = LCMP_W'(cur_r.line_index) < LCMP_W'(used_r);
  assign col_ok   = CCMP_W'(cur_r.column) < CCMP_W'(SCREEN_COLS);
  assign row_dist = used_r - UW'(1) - UW'(cur_r.line_index);
  assign row_sum  = (LW+1)'(newest_r) + (LW+1)'(SCREEN_LINES) - (LW+1)'(row_dist);
  assign row_sel  = (row_sum >= (LW+1)'(SCREEN_LINES)) ?
                    LW'(row_sum - (LW+1)'(SCREEN_LINES)) : LW'(row_sum);

  // Oldest-relative raw position to ring address
  assign raw_ok    = RCMP_W'(cur_r.raw_index) < RCMP_W'(fill_r);
  assign raw_dist  = fill_r - FW'(1) - FW'(cur_r.raw_index);
  assign raw_sum   = (DW+1)'(wp_r) + (DW+1)'(RAW_DEPTH) - (DW+1)'(1) - (DW+1)'(raw_dist);
  assign raw_raddr = (raw_sum >= (DW+1)'(RAW_DEPTH)) ?
                     DW'(raw_sum - (DW+1)'(RAW_DEPTH)) : DW'(raw_sum);

  assign cell_raddr = {row_sel, CW'(cur_r.column)};
  assign cell_waddr = {cell_wrow, cell_wcol};

  // Cells at or past a line's fill mark were never written since the line opened
  assign hw_sel = rd_newest_r ? hw_r : hw_rd_r;

  always_comb begin
    case (cur_r.op)
      tefl_pkg::OP_RD_SCREEN: begin
        rd_val = (rd_ok_r && (CCMP_W'(cur_r.column) < CCMP_W'(hw_sel))) ?
                 tefl_pkg::BYTE_W'(cell_rd_r) : '0;
      end
      tefl_pkg::OP_RD_RAW: rd_val = rd_ok_r ? raw_rd_r : '0;
      default:             rd_val = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    newest_nxt    = newest_r;
    used_nxt      = used_r;
    cursor_nxt    = cursor_r;
    hw_nxt        = hw_r;
    tab_first_nxt = tab_first_r;
    rd_ok_nxt     = rd_ok_r;
    rd_newest_nxt = rd_newest_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_take;
    result_nxt    = result_r;
    q_pop         = 1'b0;
    cell_we       = 1'b0;
    cell_re       = 1'b0;
    cell_wrow     = newest_r;
    cell_wcol     = CW'(cursor_r);
    cell_wdata    = tefl_pkg::CELL_W'(tefl_pkg::CH_SPACE);
    hw_we         = 1'b0;
    hw_re         = 1'b0;
    raw_we        = 1'b0;
    raw_re        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          cur_nxt       = q_entry;
          tab_first_nxt = 1'b1;
          state_nxt     = ST_EXEC;
          // log received bytes as they leave the queue
          if (q_entry.raw_feed) begin
            raw_we    = 1'b1;
            wp_nxt    = (wp_r == DW'(RAW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
            fill_nxt  = (fill_r < FW'(RAW_DEPTH)) ? fill_r + 1'b1 : fill_r;
            total_nxt = total_r + 1'b1;
          end
        end
      end

      ST_EXEC: begin
        state_nxt = ST_FINISH;
        case (cur_r.op)
          tefl_pkg::OP_PRINT: begin
            cell_we    = 1'b1;
            cell_wdata = cur_r.data_byte[tefl_pkg::CELL_W-1:0];
            if (cursor_r == CCW'(SCREEN_COLS)) begin
              // wrap: open a new line and draw at its first column
              hw_we      = 1'b1;
              newest_nxt = newest_inc;
              used_nxt   = used_inc;
              cell_wrow  = newest_inc;
              cell_wcol  = '0;
              cursor_nxt = CCW'(1);
              hw_nxt     = CCW'(1);
            end else begin
              cursor_nxt = cursor_inc;
              hw_nxt     = hw_grow;
            end
          end
          tefl_pkg::OP_LF: begin
            hw_we      = 1'b1;
            newest_nxt = newest_inc;
            used_nxt   = used_inc;
            cursor_nxt = '0;
            hw_nxt     = '0;
          end
          tefl_pkg::OP_CR: begin
            cursor_nxt = '0;
          end
          tefl_pkg::OP_BS: begin
            if (cursor_r != '0) begin
              cell_we    = 1'b1;
              cell_wcol  = CW'(cursor_r - 1'b1);
              cursor_nxt = cursor_r - 1'b1;
            end
          end
          tefl_pkg::OP_TAB: begin
            // fill one space per cycle up to the next stop
            if (tab_more) begin
              cell_we       = 1'b1;
              cursor_nxt    = cursor_inc;
              hw_nxt        = hw_grow;
              tab_first_nxt = 1'b0;
              state_nxt     = ST_EXEC;
            end
          end
          tefl_pkg::OP_RD_SCREEN: begin
            rd_ok_nxt     = line_ok && col_ok;
            rd_newest_nxt = (row_sel == newest_r);
            cell_re       = 1'b1;
            hw_re         = 1'b1;
          end
          tefl_pkg::OP_RD_RAW: begin
            rd_ok_nxt = raw_ok;
            raw_re    = 1'b1;
          end
          default: begin
          end
        endcase
      end

      ST_FINISH: begin
        // hold the result until the output slot frees up
        if (!out_valid_r || out_take) begin
          out_valid_nxt             = 1'b1;
          result_nxt.read_data      = rd_val;
          result_nxt.line_count     = tefl_pkg::LINE_CNT_W'(used_r);
          result_nxt.cursor_column  = tefl_pkg::CUR_COL_W'(cursor_r);
          result_nxt.raw_level      = tefl_pkg::RAW_CNT_W'(fill_r);
          result_nxt.total_received = total_r;
          result_nxt.parser_state   = cur_r.pstate;
          state_nxt                 = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rd_r <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (hw_we) begin
      hw_mem[newest_r] <= hw_r;
    end
    if (hw_re) begin
      hw_rd_r <= hw_mem[row_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (raw_we) begin
      raw_mem[wp_r] <= q_entry.data_byte;
    end
    if (raw_re) begin
      raw_rd_r <= raw_mem[raw_raddr];
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    rd_ok_r     <= rd_ok_nxt;
    rd_newest_r <= rd_newest_nxt;
    result_r    <= result_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      newest_r    <= '0;
      used_r      <= UW'(1);
      cursor_r    <= '0;
      hw_r        <= '0;
      tab_first_r <= 1'b0;
      wp_r        <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      used_r      <= used_nxt;
      cursor_r    <= cursor_nxt;
      hw_r        <= hw_nxt;
      tab_first_r <= tab_first_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

  `TEFL_ASSERT(a_cursor_in_line, cursor_r <= CCW'(SCREEN_COLS), "cursor past line end")
  `TEFL_ASSERT(a_fill_mark_covers_cursor, hw_r >= cursor_r, "fill mark behind cursor")
  `TEFL_ASSERT(a_lines_in_range, used_r != '0 && used_r <= UW'(SCREEN_LINES), "bad line count")
  `TEFL_ASSERT_IMP(a_pop_only_idle, q_pop, state_r == ST_IDLE, "queue popped while busy")
  `TEFL_ASSERT_NXT(a_result_held, out_valid_r && !out_take && state_r == ST_FINISH,
                   state_r == ST_FINISH, "result finished into a full slot")

endmodule

>>> rtl/core/terminal_escape_filter_line_buffer.sv
// Terminal escape filter with a screen line ring and a raw byte log.
// Input channel: push/full with command, data_byte, line_index, column, raw_index;
//   a word is taken when in_push is high and in_full is low.
// Result channel: empty/pop; one result word per input word, in order, with the
//   read byte and the line count, cursor, raw count, received total and parser
//   state as they stand after that word.
// Path: an accepted word passes the queue, then the back end's pop, execute and
//   finish steps, before its result shows; a tab repeats execute per space (up to 8).
// Flow: the back end handles one word at a time; the front end and a 2-entry
//   queue take words meanwhile, so in_full rises only when the queue holds two.
// Reset: parser normal, one empty screen line, empty raw log, total zero; no
//   clearing pass, the block takes words in the first cycle after reset.
// Stall: a result waits on the output until popped; the back end then holds its
//   next finished word, the queue fills and in_full is raised.
// Depends on tefl_pkg, tefl_front, tefl_queue and tefl_back.
module terminal_escape_filter_line_buffer #(
  parameter int SCREEN_LINES = tefl_pkg::DEF_SCREEN_LINES,
  parameter int SCREEN_COLS  = tefl_pkg::DEF_SCREEN_COLS,
  parameter int RAW_DEPTH    = tefl_pkg::DEF_RAW_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [tefl_pkg::CMD_W-1:0]      in_command,
  input  logic [tefl_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic [tefl_pkg::LINE_IDX_W-1:0] in_line_index,
  input  logic [tefl_pkg::COL_W-1:0]      in_column,
  input  logic [tefl_pkg::RAW_IDX_W-1:0]  in_raw_index,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [tefl_pkg::BYTE_W-1:0]     out_read_data,
  output logic [tefl_pkg::LINE_CNT_W-1:0] out_line_count,
  output logic [tefl_pkg::CUR_COL_W-1:0]  out_cursor_column,
  output logic [tefl_pkg::RAW_CNT_W-1:0]  out_raw_level,
  output logic [tefl_pkg::TOTAL_W-1:0]    out_total_received,
  output logic [tefl_pkg::PSTATE_W-1:0]   out_parser_state
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  tefl_pkg::entry_t  push_entry;
  tefl_pkg::entry_t  pop_entry;
  logic              out_valid;
  tefl_pkg::result_t result;

  tefl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_command    (in_command),
    .in_data_byte  (in_data_byte),
    .in_line_index (in_line_index),
    .in_column     (in_column),
    .in_raw_index  (in_raw_index),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  tefl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  tefl_back #(
    .SCREEN_LINES (SCREEN_LINES),
    .SCREEN_COLS  (SCREEN_COLS),
    .RAW_DEPTH    (RAW_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (pop_entry),
    .q_pop      (q_pop),
    .out_pop    (out_pop),
    .out_valid  (out_valid),
    .out_result (result)
  );

  assign in_full            = q_full;
  assign out_empty          = !out_valid;
  assign out_read_data      = result.read_data;
  assign out_line_count     = result.line_count;
  assign out_cursor_column  = result.cursor_column;
  assign out_raw_level      = result.raw_level;
  assign out_total_received = result.total_received;
  assign out_parser_state   = result.parser_state;

endmodule
